### hdl/swmc_pkg.sv
package swmc_pkg;
  localparam int unsigned DefMaxWindow = 256;
  localparam int unsigned DefSampleWidth = 32;
  localparam int unsigned CfgWidth = 9;
  localparam int unsigned MedianWidth = 32;
  localparam int unsigned CostWidth = 40;

  // Per-cell command broadcast along the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;
endpackage

### hdl/sliding_window_median_cost.sv
// Streaming sliding-window median: each request carries one sample; once the
// window holds window_size samples (0 reads as 1, values above MAX_WINDOW
// saturate), every request returns the lower median of the window and the sum of
// absolute deviations from it, then the oldest sample leaves. Samples sit in a row
// of compare-and-shift cells kept in sorted order, with an arrival ring memory
// beside it. A sample that does not complete the window is inserted, and then the
// block returns to idle. A sample that completes a window of k samples is
// inserted; then the k occupied cells rotate past the head while the median is
// picked up and the deviation sum is accumulated, the output register is loaded
// (delayed while an earlier result still waits there), the oldest sample is evicted
// through the read, remove and post-remove states, and the block returns to idle.
// Shrinking the window adds an eviction for each surplus sample. Outputs are held
// in a register, so the next sample is taken while a result waits.
// Configuration is accepted only while the block is idle.
module sliding_window_median_cost
  import swmc_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = DefMaxWindow,
  parameter int unsigned SAMPLE_WIDTH = DefSampleWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgWidth-1:0]          cfg_data_i,   // window_size
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata, // sample[31:0]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [79:0]                  m_axis_tdata  // median[31:0], cost[71:32]
);
  localparam int unsigned N    = MAX_WINDOW;
  localparam int unsigned AW   = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW   = $clog2(N + 1);
  localparam int unsigned SumW = CW + 1;
  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned AccW = SW + CW + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StEvRd  = 3'd1;
  localparam logic [2:0] StEvRm  = 3'd2;
  localparam logic [2:0] StIns   = 3'd3;
  localparam logic [2:0] StSum   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam logic [2:0] StPostR = 3'd7;

  logic [2:0] st_q, st_d;
  logic [CfgWidth-1:0] wsize_q;
  logic [CW-1:0] fill_q, fill_d, kk, mid;
  logic [AW-1:0] old_q, old_d, old_nx;
  logic [CW-1:0] cnt_q, cnt_d;
  logic post_q, post_d;
  logic signed [SW-1:0] samp_q, samp_d, med_q, med_d, rem_q, rem_d;
  logic signed [AccW-1:0] acc_q, acc_d, cost_fin;
  logic ovld_q, ovld_d;
  logic [MedianWidth-1:0] omed_q, omed_d;
  logic [CostWidth-1:0] ocost_q, ocost_d;
  logic signed [SW-1:0] ring [N];
  logic signed [SW-1:0] ring_rd_q;
  logic ring_we;
  logic [AW-1:0] ring_wa;
  logic [SumW-1:0] wa_sum;

  cell_cmd_t cmd;
  logic shift_en;
  logic signed [SW-1:0] cval [N];
  logic cvld [N];
  logic cgt [N];

  // Effective window size.
  always_comb begin
    if (wsize_q == '0) begin
      kk = CW'(1);
    end else if (32'(wsize_q) > N) begin
      kk = CW'(N);
    end else begin
      kk = CW'(wsize_q);
    end
  end

  // Rank of the lower median, counted from zero.
  assign mid = (kk - CW'(1)) >> 1;

  assign cfg_ready_o   = (st_q == StIdle);
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {8'd0, ocost_q, omed_q};

  // Sorted row of cells; while rotating, the last occupied cell takes the head.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [SW-1:0] lv, rv, sv;
    logic lg, lvl, rvl;
    if (g == 0) begin : g_l
      assign lv = '0; assign lvl = 1'b0; assign lg = 1'b0;
    end else begin : g_l
      assign lv = cval[g-1]; assign lvl = cvld[g-1]; assign lg = cgt[g-1];
    end
    if (g == N - 1) begin : g_r
      assign rv = '0; assign rvl = 1'b0; assign sv = cval[0];
    end else begin : g_r
      assign rv = cval[g+1]; assign rvl = cvld[g+1];
      assign sv = cvld[g+1] ? cval[g+1] : cval[0];
    end
    swmc_cell #(.SW(SW)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .ins_val_i(samp_q), .rem_val_i(rem_q),
      .is_first_i(g == 0), .left_val_i(lv), .left_vld_i(lvl), .left_gt_i(lg),
      .right_val_i(rv), .right_vld_i(rvl),
      .shift_val_i(sv), .shift_en_i(shift_en),
      .val_o(cval[g]), .vld_o(cvld[g]), .gt_o(cgt[g])
    );
  end

  // Samples above the median add, samples below subtract; for an even window the
  // median itself is taken off once more, which gives the absolute deviation sum.
  assign cost_fin = kk[0] ? acc_q : (acc_q - AccW'(med_q));

  // Ring write slot, wrapped by compare and subtract, and the next oldest slot.
  assign wa_sum  = SumW'(old_q) + SumW'(fill_q);
  assign ring_wa = (wa_sum >= SumW'(N)) ? AW'(wa_sum - SumW'(N)) : AW'(wa_sum);
  assign old_nx  = (32'(old_q) == N - 1) ? '0 : (old_q + AW'(1));

  // Sequencer.
  always_comb begin
    st_d = st_q; fill_d = fill_q; old_d = old_q; cnt_d = cnt_q; post_d = post_q;
    samp_d = samp_q; med_d = med_q; rem_d = rem_q; acc_d = acc_q;
    ovld_d = ovld_q; omed_d = omed_q; ocost_d = ocost_q;
    cmd = '0; shift_en = 1'b0; ring_we = 1'b0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          samp_d = s_axis_tdata[SW-1:0];
          st_d = (fill_q >= kk) ? StEvRd : StIns;
        end
      end
      StEvRd: st_d = StEvRm;
      StEvRm: begin
        rem_d = ring_rd_q;
        st_d = StPostR;
      end
      StPostR: begin
        cmd.rem = 1'b1;
        fill_d = fill_q - CW'(1);
        old_d = old_nx;
        if (post_q) begin
          post_d = 1'b0;
          st_d = StIdle;
        end else begin
          st_d = ((fill_q - CW'(1)) >= kk) ? StEvRd : StIns;
        end
      end
      StIns: begin
        cmd.ins = 1'b1;
        ring_we = 1'b1;
        fill_d = fill_q + CW'(1);
        st_d = StIdle;
        if (fill_q + CW'(1) == kk) begin
          st_d = StSum; cnt_d = '0; acc_d = '0;
        end
      end
      StSum: begin
        // The head cell holds the sample of rank cnt_q.
        shift_en = 1'b1;
        if (cnt_q == mid) begin
          med_d = cval[0];
        end else if (cnt_q > mid) begin
          acc_d = acc_q + AccW'(cval[0]);
        end else begin
          acc_d = acc_q - AccW'(cval[0]);
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == kk - CW'(1)) st_d = StOut;
      end
      StOut: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1;
          omed_d = MedianWidth'(med_q);
          ocost_d = CostWidth'(cost_fin);
          post_d = 1'b1;
          st_d = StEvRd;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; wsize_q <= CfgWidth'(1); fill_q <= '0; old_q <= '0;
      ovld_q <= 1'b0; cnt_q <= '0; post_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; old_q <= old_d; ovld_q <= ovld_d;
      cnt_q <= cnt_d; post_q <= post_d;
      if (cfg_valid_i && cfg_ready_o) wsize_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d; med_q <= med_d; rem_q <= rem_d; acc_q <= acc_d;
    omed_q <= omed_d; ocost_q <= ocost_d;
    if (ring_we) ring[ring_wa] <= samp_q;
    ring_rd_q <= ring[old_q];
  end
endmodule

### hdl/swmc_cell.sv
module swmc_cell
  import swmc_pkg::*;
#(
  parameter int unsigned SW = DefSampleWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_cmd_t            cmd_i,
  input  logic signed [SW-1:0] ins_val_i,
  input  logic signed [SW-1:0] rem_val_i,
  input  logic                 is_first_i,
  input  logic signed [SW-1:0] left_val_i,
  input  logic                 left_vld_i,
  input  logic                 left_gt_i,
  input  logic signed [SW-1:0] right_val_i,
  input  logic                 right_vld_i,
  input  logic signed [SW-1:0] shift_val_i,
  input  logic                 shift_en_i,
  output logic signed [SW-1:0] val_o,
  output logic                 vld_o,
  output logic                 gt_o
);
  logic signed [SW-1:0] val_q, val_d;
  logic vld_q, vld_d;
  logic hit;

  // This cell holds a value greater than the new sample (or is empty).
  assign gt_o  = !vld_q || (val_q > ins_val_i);
  // The row is ascending, so the first cell at or above the removed value is
  // the match and every cell to its right moves left as well.
  assign hit   = !vld_q || (val_q >= rem_val_i);
  assign val_o = val_q;
  assign vld_o = vld_q;

  // Insert shifts right where greater; remove shifts left from the match on.
  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (shift_en_i) begin
      val_d = shift_val_i;
    end else if (cmd_i.ins && gt_o) begin
      if (is_first_i || !left_gt_i) begin
        val_d = ins_val_i;
        vld_d = 1'b1;
      end else begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end
    end else if (cmd_i.rem && hit) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
endmodule
